// ----- design/ssnf_pkg.sv -----
// ---------------------------------------------------------------------------
// ssnf_pkg
// Shared types and constants for the seven-segment number formatter.
// ---------------------------------------------------------------------------
package ssnf_pkg;

   localparam int MAG_W      = 26;  // magnitude of the 26-bit two's complement input
   localparam int MAX_DIGITS = 8;   // decimal digits of the largest magnitude, 2^25
   localparam int DIG_IDX_W  = 3;
   localparam int DIG_CNT_W  = 4;

   // x / 10 == (x * DIV10_MULT) >> DIV10_SHIFT for every x below 2^26
   localparam int          DIV10_SHIFT = 29;
   localparam logic [25:0] DIV10_MULT  = 26'd53687092;

   localparam logic [7:0] CODE_MINUS = 8'h0A;
   localparam logic [7:0] CODE_BLANK = 8'h0F;
   localparam logic [7:0] CODE_POINT = 8'h80;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXTRACT,
      ST_EMIT
   } state_type;

endpackage

// ----- design/seven_segment_number_formatter.sv -----
// ---------------------------------------------------------------------------
// seven_segment_number_formatter
// Formats a signed number in thousandths as code-B digit writes.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low. The magnitude is then
// split into decimal digits by one shared divide-by-ten unit, one digit per
// cycle (at least FRACTION_DIGITS+1 digits, at most 8), after which the
// DIGIT_POSITIONS writes follow on consecutive cycles, rightmost position
// first, each marked by rsp_strobe for one cycle. busy stays high until the
// last write, and the next word is taken only once back in idle; the
// receiver cannot stall and must take every write in the cycle it appears.
// rsp_overflow is known before the first write and holds the same value on
// all of them.
module seven_segment_number_formatter #(
   parameter int DIGIT_POSITIONS = 8,
   parameter int FRACTION_DIGITS = 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [25:0]  req_value_milli,
   output logic                rsp_strobe,
   output logic [3:0]          rsp_digit_position,
   output logic [7:0]          rsp_segment_code,
   output logic                rsp_last_write,
   output logic                rsp_overflow
);

   localparam int POS_W = (DIGIT_POSITIONS > 1) ? $clog2(DIGIT_POSITIONS) : 1;
   localparam int CNT_W = ssnf_pkg::DIG_CNT_W;

   ssnf_pkg::state_type state_ff, state_in;

   logic [ssnf_pkg::MAG_W-1:0] value_ff, value_in;
   logic                       neg_ff, neg_in;
   logic                       frac_nz_ff, frac_nz_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [3:0]                 dig_ff [ssnf_pkg::MAX_DIGITS];
   logic [3:0]                 dig_in [ssnf_pkg::MAX_DIGITS];

   logic [ssnf_pkg::MAG_W-1:0] quotient;
   logic [3:0]                 remainder;
   logic [ssnf_pkg::MAG_W-1:0] raw;
   logic                       accept;
   logic [CNT_W-1:0]           body_len;
   logic [CNT_W-1:0]           pos_ext;
   logic [CNT_W-1:0]           rd_idx;
   logic [7:0]                 code;

   ssnf_div10 u_div10 (
      .dividend  (value_ff),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign raw    = ssnf_pkg::MAG_W'(req_value_milli);
   assign accept = start && (state_ff == ssnf_pkg::ST_IDLE);

   // number of digit codes before the sign slot
   assign body_len = frac_nz_ff ? count_ff : (count_ff - CNT_W'(FRACTION_DIGITS));
   assign pos_ext  = CNT_W'(pos_ff);
   assign rd_idx   = frac_nz_ff ? pos_ext : (pos_ext + CNT_W'(FRACTION_DIGITS));

   always_comb begin
      if (pos_ext < body_len) begin
         code = {4'b0, dig_ff[rd_idx[ssnf_pkg::DIG_IDX_W-1:0]]};
         if (frac_nz_ff && (pos_ext == CNT_W'(FRACTION_DIGITS))) begin
            code = code | ssnf_pkg::CODE_POINT;
         end
      end else if ((pos_ext == body_len) && neg_ff) begin
         code = ssnf_pkg::CODE_MINUS;
      end else begin
         code = ssnf_pkg::CODE_BLANK;
      end
   end

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      neg_in     = neg_ff;
      frac_nz_in = frac_nz_ff;
      count_in   = count_ff;
      pos_in     = pos_ff;
      dig_in     = dig_ff;

      unique case (state_ff)
         ssnf_pkg::ST_IDLE: begin
            if (accept) begin
               neg_in     = raw[ssnf_pkg::MAG_W-1];
               value_in   = raw[ssnf_pkg::MAG_W-1] ? (~raw + 1'b1) : raw;
               frac_nz_in = 1'b0;
               count_in   = '0;
               pos_in     = '0;
               state_in   = ssnf_pkg::ST_EXTRACT;
            end
         end
         ssnf_pkg::ST_EXTRACT: begin
            dig_in[count_ff[ssnf_pkg::DIG_IDX_W-1:0]] = remainder;
            value_in = quotient;
            count_in = count_ff + 1'b1;
            if (count_ff < CNT_W'(FRACTION_DIGITS)) begin
               frac_nz_in = frac_nz_ff || (remainder != 4'd0);
            end else if (quotient == '0) begin
               // at least one integer digit, then stop at the leading digit
               state_in = ssnf_pkg::ST_EMIT;
            end
         end
         ssnf_pkg::ST_EMIT: begin
            pos_in = pos_ff + 1'b1;
            if (pos_ff == POS_W'(DIGIT_POSITIONS - 1)) begin
               pos_in   = '0;
               state_in = ssnf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssnf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssnf_pkg::ST_IDLE;
         pos_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      neg_ff     <= neg_in;
      frac_nz_ff <= frac_nz_in;
      dig_ff     <= dig_in;
   end

   assign busy               = (state_ff != ssnf_pkg::ST_IDLE);
   assign rsp_strobe         = (state_ff == ssnf_pkg::ST_EMIT);
   assign rsp_digit_position = 4'(pos_ff) + 4'd1;
   assign rsp_segment_code   = code;
   assign rsp_last_write     = (pos_ff == POS_W'(DIGIT_POSITIONS - 1));
   // sign slot sits at body_len; a blank sign that falls off is no overflow
   assign rsp_overflow       = neg_ff ? ((body_len + 1'b1) > CNT_W'(DIGIT_POSITIONS))
                                      : (body_len > CNT_W'(DIGIT_POSITIONS));

endmodule

// ----- design/ssnf_div10.sv -----
// ---------------------------------------------------------------------------
// ssnf_div10
// Divide by ten through a reciprocal multiply; gives quotient and remainder.
// ---------------------------------------------------------------------------
module ssnf_div10 (
   input  logic [ssnf_pkg::MAG_W-1:0] dividend,
   output logic [ssnf_pkg::MAG_W-1:0] quotient,
   output logic [3:0]                 remainder
);

   logic [2*ssnf_pkg::MAG_W-1:0] product;
   logic [ssnf_pkg::MAG_W-1:0]   times_ten;

   assign product  = (2*ssnf_pkg::MAG_W)'(dividend)
                   * (2*ssnf_pkg::MAG_W)'(ssnf_pkg::DIV10_MULT);
   assign quotient = ssnf_pkg::MAG_W'(product[2*ssnf_pkg::MAG_W-1:ssnf_pkg::DIV10_SHIFT]);

   // q*10 never exceeds the dividend, so no carry is lost
   assign times_ten = (quotient << 3) + (quotient << 1);
   assign remainder = 4'(dividend - times_ten);

endmodule
